// File: hdl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Sizes, codes and the command and status bundles shared by the decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int DICT_DEPTH     = 4096;
    localparam int HISTORY_DEPTH  = 65536;
    localparam int MAX_STRING_LEN = 32;
    localparam int MAX_CODE_BITS  = 13;

    localparam int CODE_W  = MAX_CODE_BITS;
    localparam int ECNT_W  = $clog2(DICT_DEPTH + 1);
    localparam int EIDX_W  = $clog2(DICT_DEPTH);
    localparam int HADDR_W = $clog2(HISTORY_DEPTH);
    localparam int LEN_W   = 6;
    localparam int OLEN_W  = 17;

    localparam int FIRST_WIDTH = 9;
    localparam int LIT_BASE    = 3;
    localparam int DICT_BASE   = 259;
    localparam int WORD_BITS   = 16;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_RESERVED = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG = 3'd3;
    localparam logic [2:0] ERR_FULL     = 3'd4;

    localparam logic [1:0] CMD_START = 2'd0;

    typedef struct packed {
        logic clear;
        logic load_word;
        logic put_err_status;
        logic code_load;
        logic put_err;
        logic put_lit;
        logic str_init;
        logic put_hist;
        logic entry_add;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic       err_active;
        logic       finished;
        logic [2:0] chk_err;
        logic       is_lit;
        logic       len_zero;
        logic       can_put;
        logic       str_more;
        logic       loop_more;
        logic       hold_valid;
        logic       out_free;
    } t_dp_stat;

endpackage

// File: hdl/lzwd_if.sv
// ----------------------------------------------------------------------------
// LZW decoder channels
// Valid/ready interfaces for the word input and the byte output.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] data_word;

    modport source (output valid, output command, output data_word, input ready);
    modport sink   (input valid, input command, input data_word, output ready);
endinterface

interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       done_res;
    logic [2:0] error_code;

    modport source (output valid, output out_byte, output last, output done_res,
                    output error_code, input ready);
    modport sink   (input valid, input out_byte, input last, input done_res,
                    input error_code, output ready);
endinterface

// File: hdl/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// LZW decoder controller
// Sequences code extraction, checks, string copy and dictionary update.
// ----------------------------------------------------------------------------
module lzwd_ctrl
    import lzwd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_command,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CODE, S_CHECK, S_RD, S_BYTE, S_ENTRY, S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        o_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_START[0]) begin
                        o_cmd.clear = 1'b1;
                    end else if (i_stat.err_active) begin
                        o_cmd.put_err_status = 1'b1;
                        n_state = S_FLUSH;
                    end else if (!i_stat.finished) begin
                        o_cmd.load_word = 1'b1;
                        n_state = S_CODE;
                    end
                end
            end
            S_CODE: begin
                o_cmd.code_load = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_stat.chk_err != ERR_NONE) begin
                    if (i_stat.can_put) begin
                        o_cmd.put_err = 1'b1;
                        n_state = S_FLUSH;
                    end
                end else if (i_stat.is_lit) begin
                    if (i_stat.can_put) begin
                        o_cmd.put_lit = 1'b1;
                        n_state = S_ENTRY;
                    end
                end else begin
                    o_cmd.str_init = 1'b1;
                    n_state = i_stat.len_zero ? S_ENTRY : S_RD;
                end
            end
            S_RD: begin
                n_state = S_BYTE;
            end
            S_BYTE: begin
                if (i_stat.can_put) begin
                    o_cmd.put_hist = 1'b1;
                    n_state = i_stat.str_more ? S_RD : S_ENTRY;
                end
            end
            S_ENTRY: begin
                o_cmd.entry_add = 1'b1;
                n_state = i_stat.loop_more ? S_CODE : S_FLUSH;
            end
            S_FLUSH: begin
                if (!i_stat.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/lzwd_dp.sv
// ----------------------------------------------------------------------------
// LZW decoder datapath
// Bit buffer, counters, dictionary and history memories, result staging.
// ----------------------------------------------------------------------------
module lzwd_dp
    import lzwd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [OLEN_W-1:0]   i_cfg_data,
    input  logic [15:0]         i_data_word,
    input  logic                i_out_ready,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last,
    output logic                o_out_done,
    output logic [2:0]          o_out_err
);

    logic [OLEN_W-1:0]  r_olen;
    logic [31:0]        r_buf;
    logic [4:0]         r_held;
    logic [3:0]         r_cw;
    logic [ECNT_W-1:0]  r_ecnt;
    logic [OLEN_W-1:0]  r_bout;
    logic [2:0]         r_estat;
    logic [CODE_W-1:0]  r_code;
    logic [HADDR_W-1:0] r_start;
    logic [HADDR_W-1:0] r_spos;
    logic [LEN_W-1:0]   r_slen;
    logic [LEN_W-1:0]   r_idx;
    logic [LEN_W-1:0]   r_newlen;

    logic               r_hvalid;
    logic [7:0]         r_hbyte;
    logic               r_hdone;
    logic [2:0]         r_herr;

    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic               r_olast;
    logic               r_odone;
    logic [2:0]         r_oerr;

    logic [HADDR_W-1:0] ent_start_mem [DICT_DEPTH];
    logic [LEN_W-1:0]   ent_len_mem   [DICT_DEPTH];
    logic [7:0]         hist_mem      [HISTORY_DEPTH];
    logic [HADDR_W-1:0] r_ent_start;
    logic [LEN_W-1:0]   r_ent_len;
    logic [7:0]         r_hist_rd;

    logic [31:0]        mask;
    logic [4:0]         shamt;
    logic [CODE_W-1:0]  code_now;
    logic [CODE_W-1:0]  ent_raddr_code;
    logic [EIDX_W-1:0]  ent_raddr;
    logic [HADDR_W-1:0] hist_raddr;
    logic [HADDR_W-1:0] bout_addr;
    logic [31:0]        code_ext;
    logic               is_dict;
    logic               grow;
    logic               out_free;
    logic               can_put;
    logic               do_put;
    logic [7:0]         put_byte;
    logic               put_done;
    logic [2:0]         put_err;
    logic [2:0]         chk_err;
    logic [OLEN_W-1:0]  bout_inc;

    assign mask      = (32'd1 << r_cw) - 32'd1;
    assign shamt     = r_held - 5'(r_cw);
    assign code_now  = CODE_W'((r_buf >> shamt) & mask);
    assign code_ext  = 32'(r_code);
    assign is_dict   = (code_ext >= 32'(DICT_BASE));
    assign bout_addr = HADDR_W'(r_bout);
    assign bout_inc  = r_bout + OLEN_W'(1);
    assign out_free  = !r_ovalid || i_out_ready;
    assign can_put   = !r_hvalid || out_free;
    // The next entry pushes the table past the largest code of this width.
    assign grow      = (32'(r_ecnt) + 32'd1 + 32'(DICT_BASE) > mask)
                       && (32'(r_cw) < 32'(MAX_CODE_BITS));

    assign ent_raddr_code = i_cmd.code_load ? code_now : r_code;
    assign ent_raddr      = EIDX_W'(32'(ent_raddr_code) - 32'(DICT_BASE));
    assign hist_raddr     = r_spos + HADDR_W'(r_idx);

    always_comb begin
        priority if (code_ext < 32'(LIT_BASE)) begin
            chk_err = ERR_RESERVED;
        end else if (is_dict && (code_ext - 32'(DICT_BASE) >= 32'(r_ecnt))) begin
            chk_err = ERR_UNKNOWN;
        end else if (is_dict && (32'(r_ent_len) > 32'(MAX_STRING_LEN))) begin
            chk_err = ERR_TOO_LONG;
        end else if (32'(r_ecnt) >= 32'(DICT_DEPTH)) begin
            chk_err = ERR_FULL;
        end else begin
            chk_err = ERR_NONE;
        end
    end

    always_comb begin
        do_put   = i_cmd.put_err_status || i_cmd.put_err || i_cmd.put_lit
                   || i_cmd.put_hist;
        put_byte = 8'd0;
        put_err  = ERR_NONE;
        put_done = (r_bout >= r_olen);
        priority if (i_cmd.put_err_status) begin
            put_err = r_estat;
        end else if (i_cmd.put_err) begin
            put_err = chk_err;
        end else if (i_cmd.put_lit) begin
            put_byte = 8'(code_ext - 32'(LIT_BASE));
            put_done = (bout_inc >= r_olen);
        end else if (i_cmd.put_hist) begin
            put_byte = r_hist_rd;
            put_done = (bout_inc >= r_olen);
        end else begin
            put_byte = 8'd0;
        end
    end

    always_comb begin
        o_stat.err_active = (r_estat != ERR_NONE);
        o_stat.finished   = (r_bout >= r_olen);
        o_stat.chk_err    = chk_err;
        o_stat.is_lit     = !is_dict;
        o_stat.len_zero   = (r_ent_len == '0) || (r_bout >= r_olen);
        o_stat.can_put    = can_put;
        o_stat.str_more   = (r_idx + LEN_W'(1) < r_slen) && (bout_inc < r_olen);
        o_stat.loop_more  = !grow && (r_held >= 5'(WORD_BITS)) && (r_bout < r_olen);
        o_stat.hold_valid = r_hvalid;
        o_stat.out_free   = out_free;
    end

    // Memories: one write port and registered reads.
    always_ff @(posedge i_clk) begin
        r_ent_start <= ent_start_mem[ent_raddr];
        r_ent_len   <= ent_len_mem[ent_raddr];
        r_hist_rd   <= hist_mem[hist_raddr];
        if (i_cmd.entry_add) begin
            ent_start_mem[EIDX_W'(r_ecnt)] <= r_start;
            ent_len_mem[EIDX_W'(r_ecnt)]   <= r_newlen;
        end
        if (i_cmd.put_lit || i_cmd.put_hist) begin
            hist_mem[bout_addr] <= put_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olen   <= '0;
            r_buf    <= '0;
            r_held   <= '0;
            r_cw     <= 4'(FIRST_WIDTH);
            r_ecnt   <= '0;
            r_bout   <= '0;
            r_estat  <= ERR_NONE;
            r_hvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_olen <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_buf   <= '0;
                r_held  <= '0;
                r_cw    <= 4'(FIRST_WIDTH);
                r_ecnt  <= '0;
                r_bout  <= '0;
                r_estat <= ERR_NONE;
            end
            if (i_cmd.load_word) begin
                r_buf  <= {r_buf[15:0], i_data_word};
                r_held <= r_held + 5'(WORD_BITS);
            end
            if (i_cmd.code_load) begin
                r_code  <= code_now;
                r_held  <= r_held - 5'(r_cw);
                r_start <= bout_addr;
            end
            if (i_cmd.put_err) begin
                r_estat <= chk_err;
            end
            if (i_cmd.put_lit) begin
                r_bout   <= bout_inc;
                r_newlen <= LEN_W'(2);
            end
            if (i_cmd.str_init) begin
                r_spos   <= r_ent_start;
                r_slen   <= r_ent_len;
                r_idx    <= '0;
                r_newlen <= r_ent_len + LEN_W'(1);
            end
            if (i_cmd.put_hist) begin
                r_bout <= bout_inc;
                r_idx  <= r_idx + LEN_W'(1);
            end
            if (i_cmd.entry_add) begin
                r_ecnt <= r_ecnt + ECNT_W'(1);
                if (grow) begin
                    r_buf  <= '0;
                    r_held <= '0;
                    r_cw   <= r_cw + 4'd1;
                end
            end

            // Output stage and the held result that waits to learn its last flag.
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (do_put) begin
                if (r_hvalid) begin
                    r_ovalid <= 1'b1;
                    r_obyte  <= r_hbyte;
                    r_olast  <= 1'b0;
                    r_odone  <= r_hdone;
                    r_oerr   <= r_herr;
                end
                r_hvalid <= 1'b1;
                r_hbyte  <= put_byte;
                r_hdone  <= put_done;
                r_herr   <= put_err;
            end else if (i_cmd.flush) begin
                r_ovalid <= 1'b1;
                r_obyte  <= r_hbyte;
                r_olast  <= 1'b1;
                r_odone  <= r_hdone;
                r_oerr   <= r_herr;
                r_hvalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;
    assign o_out_done  = r_odone;
    assign o_out_err   = r_oerr;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_bout == '0) && (r_estat == ERR_NONE) && (r_ecnt == '0))
        else $error("stream start did not clear the decoder state");

    a_byte_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_hist |=> (r_bout == $past(r_bout) + OLEN_W'(1)))
        else $error("copied byte was not counted");

    a_err_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_oerr != ERR_NONE)) |-> (r_obyte == 8'd0) && r_olast)
        else $error("error transaction carries a byte or is not last");

    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_put && r_hvalid) |-> out_free)
        else $error("held result overwrote a pending output");

endmodule

// File: hdl/lzw_variable_width_decoder.sv
// ----------------------------------------------------------------------------
// LZW variable width decoder
// Unpacks MSB-first codes from 16-bit words and expands them to bytes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Handshake
//  i_in      in   command, data_word                        valid/ready
//  o_out     out  out_byte, last, done_res, error_code      valid/ready
//  cfg       in   i_cfg_data (output_length)                i_cfg_we
//
// A start command clears the decoder state. A data word is loaded, then each
// code passes through extraction, the dictionary check and the entry update,
// and each copied byte through a registered read of the history memory.
// Results are delayed by one slot so the last flag is known; a flush state
// ends each word. A stalled output stops the copy; no word is taken until the
// previous one is finished. Reset is synchronous and needs no clearing pass.
module lzw_variable_width_decoder
    import lzwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [OLEN_W-1:0] i_cfg_data,
    lzwd_in_if.sink           i_in,
    lzwd_out_if.source        o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lzwd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .o_ready   (i_in.ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lzwd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_data_word (i_in.data_word),
        .i_out_ready (o_out.ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last),
        .o_out_done  (o_out.done_res),
        .o_out_err   (o_out.error_code)
    );

endmodule

// File: sim/lzwd_checker.sv
// ----------------------------------------------------------------------------
// LZW decoder checker
// Watches the configuration port and both channels, predicts the decoded
// bytes of every word transaction and compares them with the output channel.
// ----------------------------------------------------------------------------
module lzwd_checker
    import lzwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [OLEN_W-1:0] i_cfg_data,
    lzwd_in_if                in_ch,
    lzwd_out_if               out_ch,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       done_res;
        logic [2:0] error_code;
    } t_byte_res;

    t_byte_res         byte_q[$];
    logic [OLEN_W-1:0] out_len;
    logic [31:0]       bit_buf;
    int unsigned       held;
    int unsigned       width;
    int unsigned       n_entries;
    int unsigned       n_bytes;
    logic [2:0]        sticky_err;
    int unsigned       ent_start [DICT_DEPTH];
    int unsigned       ent_len [DICT_DEPTH];
    logic [7:0]        hist [HISTORY_DEPTH];

    // The stores are not cleared: only entries written in the current stream
    // are ever read back.
    function void clear_stream();
        bit_buf    = '0;
        held       = 0;
        width      = FIRST_WIDTH;
        n_entries  = 0;
        n_bytes    = 0;
        sticky_err = ERR_NONE;
    endfunction

    function void push_res(logic [7:0] b, logic [2:0] err);
        t_byte_res r;
        r.out_byte   = b;
        r.last       = 1'b0;
        r.done_res   = (n_bytes >= out_len);
        r.error_code = err;
        byte_q.push_back(r);
    endfunction

    function void put_byte(logic [7:0] b);
        hist[n_bytes % HISTORY_DEPTH] = b;
        n_bytes++;
        push_res(b, ERR_NONE);
    endfunction

    function void decode_word(logic [15:0] word);
        int unsigned mask;
        int unsigned code;
        int unsigned start;
        int unsigned new_len;
        int unsigned e;
        int unsigned pos;
        int unsigned ln;
        int          n0;
        logic [2:0]  err;
        n0 = byte_q.size();
        if (sticky_err != ERR_NONE) begin
            push_res(8'd0, sticky_err);
            byte_q[byte_q.size()-1].last = 1'b1;
            return;
        end
        if (n_bytes >= out_len) return;
        bit_buf = {bit_buf[15:0], word};
        held    = (held + WORD_BITS) % 32;
        do begin
            mask  = (1 << width) - 1;
            code  = (bit_buf >> (held - width)) & mask;
            start = n_bytes % HISTORY_DEPTH;
            held  = held - width;
            err   = ERR_NONE;
            if (code < LIT_BASE)
                err = ERR_RESERVED;
            else if (code >= DICT_BASE && code - DICT_BASE >= n_entries)
                err = ERR_UNKNOWN;
            else if (code >= DICT_BASE && ent_len[code - DICT_BASE] > MAX_STRING_LEN)
                err = ERR_TOO_LONG;
            else if (n_entries >= DICT_DEPTH)
                err = ERR_FULL;
            if (err != ERR_NONE) begin
                sticky_err = err;
                push_res(8'd0, err);
                break;
            end
            if (code < DICT_BASE) begin
                put_byte(8'(code - LIT_BASE));
                new_len = 2;
            end else begin
                e   = code - DICT_BASE;
                pos = ent_start[e];
                ln  = ent_len[e];
                // Byte by byte, so a string may read what it has just written.
                for (int unsigned i = 0; i < ln && n_bytes < out_len; i++)
                    put_byte(hist[(pos + i) % HISTORY_DEPTH]);
                new_len = ln + 1;
            end
            ent_start[n_entries] = start;
            ent_len[n_entries]   = new_len % 64;
            n_entries++;
            if (n_entries + DICT_BASE > mask && width < MAX_CODE_BITS) begin
                bit_buf = '0;
                held    = 0;
                width++;
            end
        end while (held >= WORD_BITS && n_bytes < out_len);
        if (byte_q.size() > n0) byte_q[byte_q.size()-1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_byte_res got;
        t_byte_res exp_r;
        if (!i_rst_n) begin
            out_len      = '0;
            clear_stream();
            byte_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) out_len = i_cfg_data;
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.command) decode_word(in_ch.data_word);
                else clear_stream();
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.out_byte, out_ch.last, out_ch.done_res, out_ch.error_code};
                if (byte_q.size() == 0) begin
                    $display("%0t: result with nothing expected: actual %p", $time, got);
                    o_fail_count++;
                end else begin
                    exp_r = byte_q.pop_front();
                    if (got.out_byte !== exp_r.out_byte || got.last !== exp_r.last ||
                        got.done_res !== exp_r.done_res ||
                        got.error_code !== exp_r.error_code) begin
                        $display("%0t: mismatch: expected %p actual %p", $time, exp_r, got);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = byte_q.size();
    end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// LZW decoder testbench
// Builds well-formed code streams with width growth, plus error and noise
// streams, drives them under varying back-pressure and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import lzwd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 64;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [OLEN_W-1:0] cfg_data = '0;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    int                src_idle = 37;
    int                sink_idle = 57;
    int                words_sent = 0;
    int                code_q[$];
    logic [15:0]       word_q[$];

    lzwd_in_if  in_ch();
    lzwd_out_if out_ch();

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.command   = 1'b0;
        in_ch.data_word = '0;
        out_ch.ready    = 1'b0;
    end

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lzw_variable_width_decoder u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    lzwd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic cmd, logic [15:0] word);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.data_word <= word;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Waits until every predicted byte has arrived and the block has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Number of codes the decoder extracts when one more word is loaded.
    function automatic int codes_taken(ref int dh, input int w);
        int n;
        n  = 0;
        dh = dh + WORD_BITS;
        do begin
            dh = dh - w;
            n++;
        end while (dh >= WORD_BITS);
        return n;
    endfunction

    // Packs code_q MSB first into words. At each width increase the decoder
    // drops what it holds, so the word is padded; if the growing code would
    // still sit in the buffer when its word is loaded, a filler word follows.
    task automatic pack_codes();
        int          w;
        int          ents;
        int          nacc;
        int          dh;
        int          ex;
        int          cp;
        logic [63:0] acc;
        w = FIRST_WIDTH; ents = 0; nacc = 0; dh = 0; ex = 0; cp = 0; acc = '0;
        word_q.delete();
        foreach (code_q[i]) begin
            acc  = (acc << w) | (code_q[i] & ((1 << w) - 1));
            nacc += w;
            cp++;
            while (nacc >= WORD_BITS) begin
                word_q.push_back(16'(acc >> (nacc - WORD_BITS)));
                nacc -= WORD_BITS;
                ex += codes_taken(dh, w);
            end
            ents++;
            if (ents + DICT_BASE > (1 << w) - 1 && w < MAX_CODE_BITS) begin
                if (nacc > 0) begin
                    word_q.push_back(16'(acc << (WORD_BITS - nacc)));
                    ex += codes_taken(dh, w);
                end
                if (ex < cp) word_q.push_back(16'($urandom));
                nacc = 0; dh = 0; ex = 0; cp = 0;
                w++;
            end
        end
        if (nacc > 0)
            word_q.push_back(16'(acc << (WORD_BITS - nacc)) |
                             16'($urandom & ((1 << (WORD_BITS - nacc)) - 1)));
        word_q.push_back(16'($urandom));
    endtask

    task automatic run_stream(int out_len, bit pause_mid);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= OLEN_W'(out_len);
        @(posedge clk);
        cfg_we   <= 1'b0;
        send_item(1'b0, 16'($urandom));
        pack_codes();
        foreach (word_q[i]) begin
            if (pause_mid && i == word_q.size() / 2) drain();
            send_item(1'b1, word_q[i]);
        end
        words_sent += word_q.size();
    endtask

    // Random codes: literals, references to the newest entry (long chains)
    // and to any entry; a noisy stream ends on a reserved or unknown code.
    task automatic make_codes(int n, bit noisy, output int total);
        int lens[$];
        int e;
        int r;
        code_q.delete();
        total = 0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (lens.size() == 0 || r < 40) begin
                code_q.push_back(LIT_BASE + $urandom_range(255));
                total += 1;
                lens.push_back(2);
            end else begin
                e = (r < 70) ? lens.size() - 1 : $urandom_range(lens.size() - 1);
                if (lens[e] > MAX_STRING_LEN) e = 0;
                code_q.push_back(DICT_BASE + e);
                total += lens[e];
                lens.push_back(lens[e] + 1);
            end
        end
        if (noisy) begin
            if ($urandom_range(1)) code_q.push_back($urandom_range(LIT_BASE - 1));
            else code_q.push_back(DICT_BASE + lens.size());
        end
    endtask

    initial begin
        int total;
        int r;
        int len_sel;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length: every word is ignored.
        code_q = '{LIT_BASE, 258};
        run_stream(0, 1'b0);
        // Extreme literals, cut after one byte.
        code_q = '{LIT_BASE, 258, 100};
        run_stream(1, 1'b0);
        // Reserved code, then the sticky error on the following words.
        code_q = '{LIT_BASE, 258, 0};
        run_stream(65536, 1'b0);
        // Reference to an entry that does not exist yet.
        code_q = '{68, DICT_BASE + 1};
        run_stream(65536, 1'b0);
        // Chain of self-overlapping copies until a string is too long.
        code_q = '{100};
        for (int k = 0; k <= 30; k++) code_q.push_back(DICT_BASE + k);
        code_q.push_back(DICT_BASE + 31);
        run_stream(65536, 1'b0);
        // A copied string cut at the length limit.
        code_q = '{70, DICT_BASE, DICT_BASE + 1};
        run_stream(4, 1'b0);
        // Fill the dictionary through every code width, then one more code.
        code_q.delete();
        for (int k = 0; k <= DICT_DEPTH; k++) code_q.push_back(LIT_BASE + $urandom_range(255));
        run_stream(65536, 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            src_idle  = (phase == 0) ? 37 : (phase == 1) ? 57 : 0;
            sink_idle = (phase == 0) ? 57 : (phase == 1) ? 37 : 0;
            words_sent = 0;
            while (words_sent < 135) begin
                make_codes(($urandom_range(9) == 0) ? 300 : $urandom_range(1, 30),
                           ($urandom_range(9) == 0), total);
                r = $urandom_range(99);
                if (r < 60)      len_sel = total;
                else if (r < 75) len_sel = $urandom_range(1, total);
                else if (r < 85) len_sel = 65536;
                else if (r < 95) len_sel = total + $urandom_range(1, 50);
                else             len_sel = 0;
                run_stream(len_sel, (phase == 0 && words_sent == 0));
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
